### src/cramer_3x3_linear_solver_unit_assert.svh
// Assertion macros used by the solver top module.
`ifndef CRAMER_3X3_LINEAR_SOLVER_UNIT_ASSERT_SVH
`define CRAMER_3X3_LINEAR_SOLVER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset.
`define SLV_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("solver assertion failed");
// Next-cycle implication, checked out of reset.
`define SLV_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("solver assertion failed");
`else
`define SLV_ASSERT_IMP(lbl, ante, cons)
`define SLV_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### src/slv_pkg.sv
package slv_pkg;

    // Default entry format: Q16.16
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Pipeline control handed to each arithmetic unit
    typedef struct packed {
        logic en;
        logic valid;
    } t_pipe_ctl;

endpackage

### src/slv_det.sv
module slv_det #(
    parameter int DATA_WIDTH = slv_pkg::DATA_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  slv_pkg::t_pipe_ctl              i_ctl,
    input  logic signed [DATA_WIDTH-1:0]    i_a [9],
    output logic                            o_valid,
    output logic signed [3*DATA_WIDTH+1:0]  o_det
);

    localparam int W  = DATA_WIDTH;
    localparam int TW = 3 * W;
    localparam int DW = 3 * W + 2;

    // Sarrus terms: a[IA]*a[IB]*a[IC]; first three added, last three subtracted
    localparam int IA [6] = '{0, 1, 2, 2, 0, 1};
    localparam int IB [6] = '{4, 5, 3, 4, 5, 3};
    localparam int IC [6] = '{8, 6, 7, 6, 7, 8};

    logic signed [2*W-1:0] r_p  [6];
    logic signed [W-1:0]   r_c  [6];
    logic signed [2*W:0]   r_ml [6];
    logic signed [2*W-1:0] r_mh [6];
    logic signed [TW-1:0]  r_t  [6];
    logic signed [DW-1:0]  r_sa;
    logic signed [DW-1:0]  r_sb;
    logic signed [DW-1:0]  r_det;
    logic [4:0]            r_vld;

    logic signed [2*W-1:0] n_p  [6];
    logic signed [2*W:0]   n_ml [6];
    logic signed [2*W-1:0] n_mh [6];
    logic signed [TW-1:0]  n_t  [6];

    // Form pair products, split them into halves, then the third factor
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            n_p[i]  = i_a[IA[i]] * i_a[IB[i]];
            n_ml[i] = $signed({1'b0, r_p[i][W-1:0]}) * r_c[i];
            n_mh[i] = $signed(r_p[i][2*W-1:W]) * r_c[i];
            n_t[i]  = $signed({r_mh[i], {W{1'b0}}}) + TW'(r_ml[i]);
        end
    end

    // Advance the product and sum stages
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int i = 0; i < 6; i++) begin
                r_p[i]  <= n_p[i];
                r_c[i]  <= i_a[IC[i]];
                r_ml[i] <= n_ml[i];
                r_mh[i] <= n_mh[i];
                r_t[i]  <= n_t[i];
            end
            r_sa  <= DW'(r_t[0]) + DW'(r_t[1]) + DW'(r_t[2]);
            r_sb  <= DW'(r_t[3]) + DW'(r_t[4]) + DW'(r_t[5]);
            r_det <= r_sa - r_sb;
        end
    end

    // Carry the valid bits along with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.en) begin
            r_vld <= {r_vld[3:0], i_ctl.valid};
        end
    end

    assign o_valid = r_vld[4];
    assign o_det   = r_det;

endmodule

### src/slv_div.sv
module slv_div #(
    parameter int DATA_WIDTH = slv_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = slv_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  slv_pkg::t_pipe_ctl              i_ctl,
    input  logic signed [3*DATA_WIDTH+1:0]  i_num,
    input  logic signed [3*DATA_WIDTH+1:0]  i_den,
    output logic                            o_valid,
    output logic [DATA_WIDTH-1:0]           o_quo,
    output logic                            o_sat
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int DW = 3 * W + 2;
    localparam int RW = DW + W + F + 1;
    localparam int NS = W + 1;
    localparam logic [W:0] LIM = (W + 1)'(1) << (W - 1);

    logic [RW-1:0] r_rem [NS+1];
    logic [RW-1:0] r_den [NS+1];
    logic [W:0]    r_q   [NS+1];
    logic          r_neg [NS+1];
    logic          r_big [NS+1];
    logic          r_vld [NS+1];
    logic [W-1:0]  r_quo;
    logic          r_sat;
    logic          r_ovld;

    logic [DW-1:0] n_mn;
    logic [DW-1:0] n_md;
    logic [RW-1:0] n_num_sh;
    logic [RW-1:0] n_lim_sh;
    logic [W:0]    n_q;
    logic [W-1:0]  n_quo;
    logic          n_sat;

    // Take magnitudes, scale the numerator, flag a quotient past W+1 bits
    always_comb begin
        n_mn     = i_num[DW-1] ? (~i_num + DW'(1)) : i_num;
        n_md     = i_den[DW-1] ? (~i_den + DW'(1)) : i_den;
        n_num_sh = RW'(n_mn) << F;
        n_lim_sh = RW'(n_md) << (W + 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_rem[0] <= n_num_sh;
            r_den[0] <= RW'(n_md);
            r_q[0]   <= '0;
            r_neg[0] <= i_num[DW-1] ^ i_den[DW-1];
            r_big[0] <= n_num_sh >= n_lim_sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld[0] <= i_ctl.valid;
        end
    end

    // One restoring step per stage, quotient bit W down to bit 0
    for (genvar j = 0; j < NS; j++) begin : g_step
        logic [RW-1:0] n_dsh;
        logic          n_ge;

        always_comb begin
            n_dsh = r_den[j] << (W - j);
            n_ge  = r_rem[j] >= n_dsh;
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem[j+1] <= n_ge ? (r_rem[j] - n_dsh) : r_rem[j];
                r_den[j+1] <= r_den[j];
                r_q[j+1]   <= {r_q[j][W-1:0], n_ge};
                r_neg[j+1] <= r_neg[j];
                r_big[j+1] <= r_big[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j+1] <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld[j+1] <= r_vld[j];
            end
        end
    end

    // Apply sign and clamp to the W-bit range
    always_comb begin
        n_q = r_q[NS];
        if (!r_neg[NS]) begin
            n_sat = r_big[NS] || (n_q >= LIM);
            n_quo = n_sat ? W'(LIM - (W + 1)'(1)) : n_q[W-1:0];
        end else begin
            n_sat = r_big[NS] || (n_q > LIM);
            n_quo = n_sat ? LIM[W-1:0] : W'(~n_q + (W + 1)'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_quo <= n_quo;
            r_sat <= n_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_ctl.en) begin
            r_ovld <= r_vld[NS];
        end
    end

    assign o_valid = r_ovld;
    assign o_quo   = r_quo;
    assign o_sat   = r_sat;

endmodule

### src/cramer_3x3_linear_solver_unit.sv
// Channel   Handshake            Payload
// input     i_valid / o_stall    i_m00..i_m22, i_rhs_x, i_rhs_y, i_rhs_z
// output    o_valid / i_stall    o_sol_x, o_sol_y, o_sol_z, o_singular, o_saturated
//
// Takes one item per cycle while o_stall is low; the default entry format is Q16.16.
// The divider is restoring: one stage per quotient bit, W+1 bits.
// Reset clears only the valid bits; the pipeline is empty after reset.
// A stall on a waiting result freezes the whole pipeline; nothing is dropped.
`include "cramer_3x3_linear_solver_unit_assert.svh"

module cramer_3x3_linear_solver_unit #(
    parameter int DATA_WIDTH = slv_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = slv_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [DATA_WIDTH-1:0] i_m00,
    input  logic signed [DATA_WIDTH-1:0] i_m01,
    input  logic signed [DATA_WIDTH-1:0] i_m02,
    input  logic signed [DATA_WIDTH-1:0] i_m10,
    input  logic signed [DATA_WIDTH-1:0] i_m11,
    input  logic signed [DATA_WIDTH-1:0] i_m12,
    input  logic signed [DATA_WIDTH-1:0] i_m20,
    input  logic signed [DATA_WIDTH-1:0] i_m21,
    input  logic signed [DATA_WIDTH-1:0] i_m22,
    input  logic signed [DATA_WIDTH-1:0] i_rhs_x,
    input  logic signed [DATA_WIDTH-1:0] i_rhs_y,
    input  logic signed [DATA_WIDTH-1:0] i_rhs_z,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0] o_sol_x,
    output logic signed [DATA_WIDTH-1:0] o_sol_y,
    output logic signed [DATA_WIDTH-1:0] o_sol_z,
    output logic                         o_singular,
    output logic                         o_saturated
);

    localparam int W       = DATA_WIDTH;
    localparam int DW      = 3 * W + 2;
    localparam int DIV_LAT = W + 3;

    logic                 w_en;
    slv_pkg::t_pipe_ctl   w_det_ctl;
    slv_pkg::t_pipe_ctl   w_div_ctl;
    logic signed [W-1:0]  w_m  [9];
    logic signed [W-1:0]  w_mx [9];
    logic signed [W-1:0]  w_my [9];
    logic signed [W-1:0]  w_mz [9];
    logic signed [DW-1:0] w_det;
    logic signed [DW-1:0] w_dx;
    logic signed [DW-1:0] w_dy;
    logic signed [DW-1:0] w_dz;
    logic                 w_det_valid;
    logic                 w_div_valid;
    logic [W-1:0]         w_qx;
    logic [W-1:0]         w_qy;
    logic [W-1:0]         w_qz;
    logic                 w_sx;
    logic                 w_sy;
    logic                 w_sz;

    logic                 r_sing [DIV_LAT];
    logic                 r_out_valid;
    logic signed [W-1:0]  r_sol_x;
    logic signed [W-1:0]  r_sol_y;
    logic signed [W-1:0]  r_sol_z;
    logic                 r_singular;
    logic                 r_saturated;

    // Freeze everything while a finished item waits on a stalled output
    assign w_en      = !(r_out_valid && i_stall);
    assign o_stall   = !w_en;
    assign w_det_ctl = '{en: w_en, valid: i_valid};
    assign w_div_ctl = '{en: w_en, valid: w_det_valid};

    // Build the matrix and the three column-replaced copies
    always_comb begin
        w_m = '{i_m00, i_m01, i_m02, i_m10, i_m11, i_m12, i_m20, i_m21, i_m22};
        w_mx = w_m;
        w_my = w_m;
        w_mz = w_m;
        w_mx[0] = i_rhs_x; w_mx[3] = i_rhs_y; w_mx[6] = i_rhs_z;
        w_my[1] = i_rhs_x; w_my[4] = i_rhs_y; w_my[7] = i_rhs_z;
        w_mz[2] = i_rhs_x; w_mz[5] = i_rhs_y; w_mz[8] = i_rhs_z;
    end

    slv_det #(.DATA_WIDTH(W)) u_det_m (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_det_ctl), .i_a(w_m),
        .o_valid(w_det_valid), .o_det(w_det)
    );
    slv_det #(.DATA_WIDTH(W)) u_det_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_det_ctl), .i_a(w_mx),
        .o_valid(), .o_det(w_dx)
    );
    slv_det #(.DATA_WIDTH(W)) u_det_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_det_ctl), .i_a(w_my),
        .o_valid(), .o_det(w_dy)
    );
    slv_det #(.DATA_WIDTH(W)) u_det_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_det_ctl), .i_a(w_mz),
        .o_valid(), .o_det(w_dz)
    );

    slv_div #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_div_ctl),
        .i_num(w_dx), .i_den(w_det),
        .o_valid(w_div_valid), .o_quo(w_qx), .o_sat(w_sx)
    );
    slv_div #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_div_ctl),
        .i_num(w_dy), .i_den(w_det),
        .o_valid(), .o_quo(w_qy), .o_sat(w_sy)
    );
    slv_div #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_div_ctl),
        .i_num(w_dz), .i_den(w_det),
        .o_valid(), .o_quo(w_qz), .o_sat(w_sz)
    );

    // Delay the singular flag alongside the divider stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sing[0] <= (w_det == '0);
            for (int i = 1; i < DIV_LAT; i++) begin
                r_sing[i] <= r_sing[i-1];
            end
        end
    end

    // Register the result; a singular system gives zeros
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_singular  <= r_sing[DIV_LAT-1];
            r_saturated <= !r_sing[DIV_LAT-1] && (w_sx || w_sy || w_sz);
            r_sol_x     <= r_sing[DIV_LAT-1] ? '0 : $signed(w_qx);
            r_sol_y     <= r_sing[DIV_LAT-1] ? '0 : $signed(w_qy);
            r_sol_z     <= r_sing[DIV_LAT-1] ? '0 : $signed(w_qz);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_div_valid;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_sol_x     = r_sol_x;
    assign o_sol_y     = r_sol_y;
    assign o_sol_z     = r_sol_z;
    assign o_singular  = r_singular;
    assign o_saturated = r_saturated;

    `SLV_ASSERT_IMP(a_sing_zero, o_valid && o_singular,
        (o_sol_x == '0) && (o_sol_y == '0) && (o_sol_z == '0) && !o_saturated)
    `SLV_ASSERT_IMP(a_stall_only_full, o_stall, o_valid && i_stall)
    `SLV_ASSERT_NXT(a_hold_on_stall, o_valid && i_stall,
        o_valid && $stable(o_sol_x) && $stable(o_singular))

endmodule

### tb/sv/tb_cramer_3x3_linear_solver_unit.sv
`timescale 1ns / 1ps

module tb_cramer_3x3_linear_solver_unit;

    localparam int DW      = slv_pkg::DATA_WIDTH_DEF;
    localparam int FB      = slv_pkg::FRAC_BITS_DEF;
    localparam int WDOG    = 4000;
    localparam int HOLD    = 300;
    localparam int TAIL    = 60;

    typedef logic signed [159:0] t_wide;
    typedef t_wide t_mat[9];

    typedef struct {
        logic signed [DW-1:0] m[9];
        logic signed [DW-1:0] rhs[3];
    } t_system;

    typedef struct {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] z;
        logic                 singular;
        logic                 saturated;
    } t_solution;

    typedef struct {
        t_system   sys;
        bit        known;
        t_solution sol;
    } t_dir_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic signed [DW-1:0] i_m00, i_m01, i_m02, i_m10, i_m11, i_m12, i_m20, i_m21, i_m22;
    logic signed [DW-1:0] i_rhs_x, i_rhs_y, i_rhs_z;
    logic                 o_valid;
    logic                 i_stall;
    logic signed [DW-1:0] o_sol_x, o_sol_y, o_sol_z;
    logic                 o_singular;
    logic                 o_saturated;

    t_solution pending_solutions[$];
    t_dir_row  dir_rows[$];
    int        n_sent, n_checked, n_errors, n_singular, n_sat;
    int        send_idle_pct, stall_pct, hold_cycles, quiet_cycles;

    cramer_3x3_linear_solver_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_m00(i_m00), .i_m01(i_m01), .i_m02(i_m02),
        .i_m10(i_m10), .i_m11(i_m11), .i_m12(i_m12),
        .i_m20(i_m20), .i_m21(i_m21), .i_m22(i_m22),
        .i_rhs_x(i_rhs_x), .i_rhs_y(i_rhs_y), .i_rhs_z(i_rhs_z),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_sol_x(o_sol_x), .o_sol_y(o_sol_y), .o_sol_z(o_sol_z),
        .o_singular(o_singular), .o_saturated(o_saturated)
    );

    // Determinant by the rule of Sarrus, exact
    function automatic t_wide det3(t_mat a);
        return a[0] * a[4] * a[8] + a[1] * a[5] * a[6] + a[2] * a[3] * a[7]
             - a[2] * a[4] * a[6] - a[0] * a[5] * a[7] - a[1] * a[3] * a[8];
    endfunction

    // Quotient toward zero, clamped to the entry width
    function automatic logic signed [DW-1:0] clamp_quot(t_wide num, t_wide den, ref bit sat);
        t_wide q;
        t_wide maxv;
        t_wide minv;
        maxv = {{(160-DW){1'b0}}, 1'b0, {(DW-1){1'b1}}};
        minv = {{(160-DW){1'b1}}, 1'b1, {(DW-1){1'b0}}};
        q = (num <<< FB) / den;
        if (q > maxv) begin
            sat = 1;
            return maxv[DW-1:0];
        end
        if (q < minv) begin
            sat = 1;
            return minv[DW-1:0];
        end
        return q[DW-1:0];
    endfunction

    function automatic t_solution solve_cramer(t_system s);
        t_mat      a;
        t_mat      t;
        t_wide     det;
        t_solution r;
        bit        sat;
        logic signed [DW-1:0] c_val[3];
        sat = 0;
        for (int i = 0; i < 9; i++) a[i] = t_wide'(s.m[i]);
        det = det3(a);
        r = '{default: '0};
        if (det == 0) begin
            r.singular = 1;
            return r;
        end
        for (int c = 0; c < 3; c++) begin
            t = a;
            for (int row = 0; row < 3; row++) t[c + 3*row] = t_wide'(s.rhs[row]);
            c_val[c] = clamp_quot(det3(t), det, sat);
        end
        r.x = c_val[0];
        r.y = c_val[1];
        r.z = c_val[2];
        r.saturated = sat;
        return r;
    endfunction

    // Clock
    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Receiver stall: long hold-off when requested, random otherwise
    initial begin
        i_stall = 0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_stall <= 1;
                hold_cycles--;
            end else begin
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_solution e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_solutions.size() == 0) begin
                $error("result with no expectation waiting");
                n_errors++;
            end else begin
                e = pending_solutions.pop_front();
                n_checked++;
                if (o_sol_x !== e.x) begin
                    $error("sol_x expected %h got %h", e.x, o_sol_x);
                    n_errors++;
                end
                if (o_sol_y !== e.y) begin
                    $error("sol_y expected %h got %h", e.y, o_sol_y);
                    n_errors++;
                end
                if (o_sol_z !== e.z) begin
                    $error("sol_z expected %h got %h", e.z, o_sol_z);
                    n_errors++;
                end
                if (o_singular !== e.singular) begin
                    $error("singular expected %b got %b", e.singular, o_singular);
                    n_errors++;
                end
                if (o_saturated !== e.saturated) begin
                    $error("saturated expected %b got %b", e.saturated, o_saturated);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WDOG) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one item, hold it until taken, then record its expected solution
    task automatic send_system(t_system s, bit known, t_solution sol);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        {i_m00, i_m01, i_m02} <= {s.m[0], s.m[1], s.m[2]};
        {i_m10, i_m11, i_m12} <= {s.m[3], s.m[4], s.m[5]};
        {i_m20, i_m21, i_m22} <= {s.m[6], s.m[7], s.m[8]};
        {i_rhs_x, i_rhs_y, i_rhs_z} <= {s.rhs[0], s.rhs[1], s.rhs[2]};
        do @(posedge i_clk); while (o_stall);
        if (!known) sol = solve_cramer(s);
        if (sol.singular) n_singular++;
        if (sol.saturated) n_sat++;
        pending_solutions.push_back(sol);
        n_sent++;
    endtask

    function automatic t_system diag_system(logic signed [DW-1:0] d, logic signed [DW-1:0] off);
        t_system s;
        for (int i = 0; i < 9; i++) s.m[i] = (i % 4 == 0) ? d : off;
        s.rhs = '{default: '0};
        return s;
    endfunction

    // Random system: half well-scaled, some full range, some singular or tiny
    function automatic t_system rand_system();
        t_system s;
        int      kind;
        kind = $urandom_range(9);
        for (int i = 0; i < 9; i++) begin
            if (kind < 5) s.m[i] = $signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000;
            else s.m[i] = $urandom;
        end
        for (int i = 0; i < 3; i++) s.rhs[i] = (kind < 3) ?
            $signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000 : $urandom;
        // copy a row or a column so the determinant vanishes
        if (kind == 7) for (int i = 0; i < 3; i++) s.m[6+i] = s.m[i];
        if (kind == 8) for (int i = 0; i < 3; i++) s.m[3*i+1] = s.m[3*i];
        // near-singular: tiny diagonal, zero elsewhere
        if (kind == 9) begin
            for (int i = 0; i < 9; i++)
                s.m[i] = (i % 4 == 0) ? $signed($urandom_range(0, 6)) - 3 : '0;
        end
        return s;
    endfunction

    task automatic run_phase(int idle, int stall, int count, int hold);
        t_solution none;
        none = '{default: '0};
        send_idle_pct = idle;
        stall_pct     = stall;
        hold_cycles   = hold;
        repeat (count) send_system(rand_system(), 0, none);
    endtask

    initial begin
        t_dir_row r;
        t_solution none;
        none = '{default: '0};
        n_sent = 0; n_checked = 0; n_errors = 0; n_singular = 0; n_sat = 0;
        send_idle_pct = 0; stall_pct = 0; hold_cycles = 0; quiet_cycles = 0;
        i_rst_n = 0;
        i_valid = 0;
        {i_m00, i_m01, i_m02, i_m10, i_m11, i_m12, i_m20, i_m21, i_m22} = '0;
        {i_rhs_x, i_rhs_y, i_rhs_z} = '0;

        // All zeros: singular
        r.sys = diag_system('0, '0); r.known = 1; r.sol = '{0, 0, 0, 1, 0};
        dir_rows.push_back(r);
        // Identity with extreme right-hand side: solution equals the vector
        r.sys = diag_system(32'sh1_0000, '0);
        r.sys.rhs = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1};
        r.sol = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1, 0, 0};
        dir_rows.push_back(r);
        // Equal rows at both extremes: singular
        r.sys = diag_system(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        r.sys.rhs = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh5};
        r.sol = '{0, 0, 0, 1, 0};
        dir_rows.push_back(r);
        r.sys = diag_system(32'sh8000_0000, 32'sh8000_0000);
        r.sys.rhs = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF};
        dir_rows.push_back(r);
        // Smallest diagonal: clamp both ways, exact zero stays
        r.sys = diag_system(32'sh1, '0);
        r.sys.rhs = '{32'sh1_0000, -32'sh1_0000, '0};
        r.sol = '{32'sh7FFF_FFFF, 32'sh8000_0000, '0, 0, 1};
        dir_rows.push_back(r);
        // Remaining rows are checked against the predictor
        r.known = 0;
        r.sys = diag_system(-32'sh1, '0);
        r.sys.rhs = '{32'sh1_0000, -32'sh1_0000, 32'sh7FFF_FFFF};
        dir_rows.push_back(r);
        r.sys = diag_system(32'sh7FFF_FFFF, 32'sh8000_0000);
        r.sys.rhs = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
        dir_rows.push_back(r);
        r.sys = diag_system(32'sh8000_0000, 32'sh7FFF_FFFF);
        r.sys.rhs = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
        dir_rows.push_back(r);
        // Quotient landing exactly on the most negative value
        r.sys = diag_system(32'sh1, '0);
        r.sys.rhs = '{-32'sh8000, 32'sh7FFF, 32'sh1};
        dir_rows.push_back(r);
        // Rounding toward zero on both signs
        r.sys = diag_system(32'sh3_0000, '0);
        r.sys.m[1] = 32'sh1_0000;
        r.sys.rhs = '{32'sh1_0000, -32'sh1_0000, 32'sh2_0000};
        dir_rows.push_back(r);
        r.sys = diag_system(-32'sh3_0000, 32'sh1);
        r.sys.rhs = '{-32'sh1_0001, 32'sh1_0000, 32'sh1};
        dir_rows.push_back(r);
        for (int i = 0; i < 6; i++) begin
            r.sys = rand_system();
            dir_rows.push_back(r);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed table, no idling
        foreach (dir_rows[i]) begin
            r = dir_rows[i];
            send_system(r.sys, r.known, r.known ? r.sol : none);
        end

        // Random phases: idle and stall patterns, a long receiver hold-off, then a short run
        run_phase(0, 0, 125, 0);
        run_phase(80, 0, 100, 0);
        run_phase(0, 80, 100, 0);
        run_phase(20, 20, 125, 0);
        run_phase(0, 0, 60, HOLD);
        run_phase(0, 0, 20, 0);
        i_valid <= 0;

        // Drain
        while (pending_solutions.size() != 0) @(posedge i_clk);
        stall_pct = 0;
        repeat (TAIL) @(posedge i_clk);

        $display("Solved %0d systems: %0d singular, %0d with clamped components.",
                 n_checked, n_singular, n_sat);
        $display("Covered field extremes, idle and stall mixes, and a %0d-cycle output hold-off.",
                 HOLD);
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
